// ===== rtl/core/top_k_area_selector_top_assert.svh =====
// Assertion macros for the top-k area selector checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef TOP_K_AREA_SELECTOR_TOP_ASSERT_SVH
`define TOP_K_AREA_SELECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TKAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkas check failed");

// next-cycle implication, disabled in reset
`define TKAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkas check failed");

`endif

// ===== rtl/core/tkas_pkg.sv =====
// Shared types and constants for the top-k area selector.
// No dependencies.
package tkas_pkg;

  localparam int RANK_BITS = 3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;
    logic clear;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ===== rtl/core/tkas_if.sv =====
// Valid/ready channel interfaces for the top-k area selector.
// Uses tkas_pkg for the rank width.
interface tkas_in_if #(
  parameter int AREA_BITS  = 24,
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  carries_item;
  logic [AREA_BITS-1:0]  area;
  logic [INDEX_BITS-1:0] item_index;
  logic                  frame_end;

  modport source (output valid, carries_item, area, item_index, frame_end, input ready);
  modport sink   (input valid, carries_item, area, item_index, frame_end, output ready);
endinterface

interface tkas_out_if #(
  parameter int AREA_BITS  = 24,
  parameter int INDEX_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [tkas_pkg::RANK_BITS-1:0] rank;
  logic [AREA_BITS-1:0]           kept_area;
  logic [INDEX_BITS-1:0]          kept_index;
  logic                           is_last;

  modport source (output valid, found, rank, kept_area, kept_index, is_last, input ready);
  modport sink   (input valid, found, rank, kept_area, kept_index, is_last, output ready);
endinterface

// ===== rtl/core/tkas_ctrl.sv =====
// Controller FSM: accepts items, then drains the ranked store.
// Depends on tkas_pkg.
module tkas_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_carries_item,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tkas_pkg::dp_cmd_t    cmd,
  input  tkas_pkg::dp_status_t status
);

  tkas_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      tkas_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.insert = in_carries_item;
          if (in_frame_end) begin
            state_nxt = tkas_pkg::ST_EMIT;
          end
        end
      end
      tkas_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.step = 1'b1;
          if (status.last) begin
            cmd.clear = 1'b1;
            state_nxt = tkas_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tkas_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tkas_datapath.sv =====
// Datapath: sorted slot registers with parallel insert, held count, drain counter.
// Depends on tkas_pkg.
module tkas_datapath #(
  parameter int TOP_COUNT  = 8,
  parameter int AREA_BITS  = 24,
  parameter int INDEX_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tkas_pkg::dp_cmd_t              cmd,
  output tkas_pkg::dp_status_t           status,
  input  logic [AREA_BITS-1:0]           in_area,
  input  logic [INDEX_BITS-1:0]          in_item_index,
  output logic                           out_found,
  output logic [tkas_pkg::RANK_BITS-1:0] out_rank,
  output logic [AREA_BITS-1:0]           out_kept_area,
  output logic [INDEX_BITS-1:0]          out_kept_index,
  output logic                           out_is_last
);

  localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int CNT_W = $clog2(TOP_COUNT + 1);

  logic [AREA_BITS-1:0]  area_r  [TOP_COUNT];
  logic [AREA_BITS-1:0]  area_nxt[TOP_COUNT];
  logic [INDEX_BITS-1:0] index_r  [TOP_COUNT];
  logic [INDEX_BITS-1:0] index_nxt[TOP_COUNT];
  logic [TOP_COUNT-1:0]  valid_r, valid_nxt;
  logic [TOP_COUNT-1:0]  gt;
  logic [CNT_W-1:0]      held_r;
  logic [IDX_W-1:0]      emit_r;

  // gt is monotonic over slots: valid slots form a descending prefix.
  always_comb begin
    for (int k = 0; k < TOP_COUNT; k++) begin
      gt[k] = !valid_r[k] || (in_area > area_r[k]);
    end
    for (int k = 0; k < TOP_COUNT; k++) begin
      area_nxt[k]  = area_r[k];
      index_nxt[k] = index_r[k];
      valid_nxt[k] = valid_r[k];
      if (gt[k]) begin
        if (k == 0 || !gt[(k > 0) ? k - 1 : 0]) begin
          area_nxt[k]  = in_area;
          index_nxt[k] = in_item_index;
          valid_nxt[k] = 1'b1;
        end else begin
          area_nxt[k]  = area_r[(k > 0) ? k - 1 : 0];
          index_nxt[k] = index_r[(k > 0) ? k - 1 : 0];
          valid_nxt[k] = valid_r[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        area_r[k]  <= area_nxt[k];
        index_r[k] <= index_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      held_r  <= '0;
      emit_r  <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
      held_r  <= '0;
      emit_r  <= '0;
    end else begin
      if (cmd.insert) begin
        valid_r <= valid_nxt;
        if (gt[TOP_COUNT-1] && held_r != CNT_W'(TOP_COUNT)) begin
          held_r <= held_r + CNT_W'(1);
        end
      end
      if (cmd.step) begin
        emit_r <= emit_r + IDX_W'(1);
      end
    end
  end

  assign status.last = (held_r == '0) || ((CNT_W'(emit_r) + CNT_W'(1)) == held_r);

  // empty frame reports a single not-found item with zero payload
  assign out_found      = (held_r != '0);
  assign out_rank       = tkas_pkg::RANK_BITS'(emit_r);
  assign out_kept_area  = out_found ? area_r[emit_r] : '0;
  assign out_kept_index = out_found ? index_r[emit_r] : '0;
  assign out_is_last    = status.last;

endmodule

// ===== rtl/core/top_k_area_selector_top.sv =====
// Top level of the top-k area selector: controller plus datapath.
// Depends on tkas_pkg, tkas_in_if, tkas_out_if, tkas_ctrl, tkas_datapath.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | carries_item, area, item_index, frame_end
//  out_ch  | out | valid/ready      | found, rank, kept_area, kept_index, is_last
//
// One input item per cycle while collecting; each area is compared against all
// TOP_COUNT slots in parallel and shifted in at the accept edge.
// A frame end drains held_count items (one if empty), one per cycle at full
// out_ready; input is stalled during the drain.
// Synchronous active-low reset empties the store; no clearing pass.
// out_ch stalls hold the current item; the store clears after the last is taken.
module top_k_area_selector_top #(
  parameter int TOP_COUNT  = 8,
  parameter int AREA_BITS  = 24,
  parameter int INDEX_BITS = 16
) (
  input logic     clk,
  input logic     rst_n,
  tkas_in_if.sink   in_ch,
  tkas_out_if.source out_ch
);

  tkas_pkg::dp_cmd_t    cmd;
  tkas_pkg::dp_status_t status;

  tkas_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_carries_item(in_ch.carries_item),
    .in_frame_end   (in_ch.frame_end),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cmd            (cmd),
    .status         (status)
  );

  tkas_datapath #(
    .TOP_COUNT (TOP_COUNT),
    .AREA_BITS (AREA_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_area       (in_ch.area),
    .in_item_index (in_ch.item_index),
    .out_found     (out_ch.found),
    .out_rank      (out_ch.rank),
    .out_kept_area (out_ch.kept_area),
    .out_kept_index(out_ch.kept_index),
    .out_is_last   (out_ch.is_last)
  );

endmodule

// ===== rtl/core/tkas_checker.sv =====
// Port-level checker for the top-k area selector, bound to the top level.
// Depends on tkas_pkg and top_k_area_selector_top_assert.svh.
`include "top_k_area_selector_top_assert.svh"

module tkas_checker #(
  parameter int AREA_BITS = 24
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_frame_end,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_found,
  input logic [tkas_pkg::RANK_BITS-1:0] out_rank,
  input logic [AREA_BITS-1:0]           out_kept_area,
  input logic                           out_is_last
);

  // no new item is taken while a drain is in progress
  `TKAS_ASSERT_IMP(a_no_accept_in_drain, out_valid, !in_ready)
  // a frame end starts the drain on the next cycle
  `TKAS_ASSERT_NXT(a_drain_follows_end, in_valid && in_ready && in_frame_end, out_valid)
  // empty-frame item is alone: rank zero and flagged last
  `TKAS_ASSERT_IMP(a_empty_is_single, out_valid && !out_found,
                   out_is_last && (out_rank == '0))
  // stalled item holds
  `TKAS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_kept_area) && $stable(out_rank))

endmodule

bind top_k_area_selector_top tkas_checker #(.AREA_BITS(AREA_BITS)) u_tkas_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_frame_end (in_ch.frame_end),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_rank     (out_ch.rank),
  .out_kept_area(out_ch.kept_area),
  .out_is_last  (out_ch.is_last)
);
